// File: rtl/fvs_pkg.sv
// Package for the fair virtual-time scheduler: widths, codes, FSM states,
// and the priority-to-weight table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fvs_pkg;
	localparam int MAX_TASKS   = 64;
	localparam int TASK_W      = $clog2(MAX_TASKS);
	localparam int CNT_W       = TASK_W + 1;
	localparam int PRIO_W      = 6;
	localparam int PRIO_LEVELS = 40;
	localparam int NORMAL_PRIO = 20;
	localparam int WEIGHT_W    = 17;
	localparam int WSUM_W      = 23;
	localparam int VT_W        = 64;
	localparam int NICE0_SHIFT = 10;
	localparam int ENT_W       = 2 * VT_W + PRIO_W;

	localparam logic [1:0] ACT_TICK    = 2'd0;
	localparam logic [1:0] ACT_ENQUEUE = 2'd1;
	localparam logic [1:0] ACT_PICK    = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_DUP  = 2'd1;
	localparam logic [1:0] ST_IDLE = 2'd2;

	typedef struct packed {
		logic [VT_W-1:0]   run;
		logic [VT_W-1:0]   vt;
		logic [PRIO_W-1:0] prio;
	} task_ent_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_T_LOAD,
		S_T_DIV,
		S_T_CLAMP,
		S_T_MUL_LO,
		S_T_MUL_HI,
		S_T_SUM,
		S_T_WRITE,
		S_E_LOAD,
		S_E_SCAN,
		S_E_SCAN_ID,
		S_E_SCAN_CMP,
		S_E_SHIFT,
		S_E_SHIFT_WR,
		S_E_INSERT,
		S_P_ORDER,
		S_P_POP,
		S_REPORT
	} state_t;

	// wrap-aware order: a lies behind b
	function automatic logic behind(input logic [VT_W-1:0] a, input logic [VT_W-1:0] b);
		logic [VT_W-1:0] d;
		d = a - b;
		return d[VT_W-1];
	endfunction

	// clamp priority index to the last level
	function automatic logic [PRIO_W-1:0] prio_sat(input logic [PRIO_W-1:0] p);
		return (p >= PRIO_W'(PRIO_LEVELS)) ? PRIO_W'(PRIO_LEVELS - 1) : p;
	endfunction

	function automatic logic [WEIGHT_W-1:0] prio_weight(input logic [PRIO_W-1:0] p);
		logic [WEIGHT_W-1:0] w;
		case (prio_sat(p))
			6'd0:  w = 17'd88761;
			6'd1:  w = 17'd71755;
			6'd2:  w = 17'd56483;
			6'd3:  w = 17'd46273;
			6'd4:  w = 17'd36291;
			6'd5:  w = 17'd29154;
			6'd6:  w = 17'd23254;
			6'd7:  w = 17'd18705;
			6'd8:  w = 17'd14949;
			6'd9:  w = 17'd11916;
			6'd10: w = 17'd9548;
			6'd11: w = 17'd7620;
			6'd12: w = 17'd6100;
			6'd13: w = 17'd4904;
			6'd14: w = 17'd3906;
			6'd15: w = 17'd3121;
			6'd16: w = 17'd2501;
			6'd17: w = 17'd1991;
			6'd18: w = 17'd1586;
			6'd19: w = 17'd1277;
			6'd20: w = 17'd1024;
			6'd21: w = 17'd820;
			6'd22: w = 17'd655;
			6'd23: w = 17'd526;
			6'd24: w = 17'd423;
			6'd25: w = 17'd335;
			6'd26: w = 17'd272;
			6'd27: w = 17'd215;
			6'd28: w = 17'd172;
			6'd29: w = 17'd137;
			6'd30: w = 17'd110;
			6'd31: w = 17'd87;
			6'd32: w = 17'd70;
			6'd33: w = 17'd56;
			6'd34: w = 17'd45;
			6'd35: w = 17'd36;
			6'd36: w = 17'd29;
			6'd37: w = 17'd23;
			6'd38: w = 17'd18;
			default: w = 17'd15;
		endcase
		return w;
	endfunction
endpackage
`default_nettype wire

// File: rtl/fvs_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module fvs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, hold when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// File: rtl/fvs_div.sv
// Restoring divider, one quotient bit per cycle, for virtual-time scaling.
// Depends on fvs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fvs_div
	import fvs_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [VT_W-1:0]     dividend,
	input  wire logic [WEIGHT_W-1:0] divisor,
	output logic                     done,
	output logic      [VT_W-1:0]     quotient
);
	localparam int STEP_W = $clog2(VT_W + 1);

	logic [STEP_W-1:0]   left_q;
	logic [WEIGHT_W-1:0] rem_q;
	logic [WEIGHT_W-1:0] dvs_q;
	logic [VT_W-1:0]     quo_q;
	logic                done_q;
	logic [WEIGHT_W:0]   trial;
	logic [WEIGHT_W:0]   diff;

	// shift in next dividend bit and try subtract
	always_comb begin
		trial = {rem_q, quo_q[VT_W-1]};
		diff  = trial - {1'b0, dvs_q};
	end

	// iterate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			done_q <= 1'b0;
		end else begin
			if (start) begin
				left_q <= STEP_W'(VT_W);
			end else if (left_q != '0) begin
				left_q <= left_q - 1'b1;
			end
			done_q <= !start && (left_q == STEP_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (left_q != '0) begin
			if (!diff[WEIGHT_W]) begin
				rem_q <= diff[WEIGHT_W-1:0];
				quo_q <= {quo_q[VT_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[WEIGHT_W-1:0];
				quo_q <= {quo_q[VT_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

// File: rtl/fair_vruntime_scheduler.sv
// Weighted fair scheduler top level: sequencer, task and ready-order memories.
// Depends on fvs_pkg, fvs_ram, fvs_div.
//
// Usage: drive action, task_id and priority_req with start; a command word is
// taken at a clock edge where start is high and busy is low. Exactly one
// result word follows, shown for a single cycle with done high: task_out,
// vruntime_out, status, ready_count and weight_total. The receiver cannot
// stall; the result must be taken in that cycle.
// Sequence: pick of an empty queue, duplicate enqueue and action three go
// straight to the report state; a pick reads the order memory, then the
// task memory, then pops. A tick runs the bit-serial 64-step divider, then
// clamps, with a two-part multiply and a sum on a clamp. An enqueue scans
// queued entries (order memory read, then task memory read), then shifts
// entries toward the tail. One command is in work at a time.
// Configuration: cfg_we writes cfg_data into the idle task register at once;
// write it only while busy is low.
// Reset: clears the ready queue, count, weight sum, floor and current task.
// Task entries read as zero run and virtual time at normal priority until
// first written, tracked by one valid bit per task; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module fair_vruntime_scheduler
	import fvs_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [1:0]          action,
	input  wire logic [TASK_W-1:0]   task_id,
	input  wire logic [PRIO_W-1:0]   priority_req,
	input  wire logic                cfg_we,
	input  wire logic [TASK_W-1:0]   cfg_data,
	output logic                     done,
	output logic      [TASK_W-1:0]   task_out,
	output logic      [VT_W-1:0]     vruntime_out,
	output logic      [1:0]          status,
	output logic      [CNT_W-1:0]    ready_count,
	output logic      [WSUM_W-1:0]   weight_total
);
	state_t state_q, state_d;

	logic [TASK_W-1:0]   idle_q;
	logic [TASK_W-1:0]   cur_q;
	logic [TASK_W-1:0]   head_q;
	logic [CNT_W-1:0]    len_q;
	logic [WSUM_W-1:0]   wsum_q;
	logic [VT_W-1:0]     floor_q;
	logic [MAX_TASKS-1:0] queued_q;
	logic [MAX_TASKS-1:0] valid_q;
	logic                vld_rd_q;

	logic [TASK_W-1:0]   who_q;
	logic [1:0]          stat_q;
	logic [PRIO_W-1:0]   prio_q;
	logic [VT_W-1:0]     run_q;
	logic [VT_W-1:0]     vt_q;
	logic [WEIGHT_W-1:0] w_q;
	logic [48:0]         plo_q;
	logic [31:0]         phi_q;
	logic [CNT_W-1:0]    i_q;
	logic [CNT_W-1:0]    j_q;
	logic [CNT_W-1:0]    pos_q;

	logic                done_q;
	logic [TASK_W-1:0]   task_out_q;
	logic [VT_W-1:0]     vt_out_q;
	logic [1:0]          status_q;
	logic [CNT_W-1:0]    count_q;
	logic [WSUM_W-1:0]   weight_q;

	// memory ports
	logic                tr_we, tr_re;
	logic [TASK_W-1:0]   tr_waddr, tr_raddr;
	task_ent_t           tr_wdata, tr_rdata, ent;
	logic                or_we, or_re;
	logic [TASK_W-1:0]   or_waddr, or_raddr, or_wdata, or_rdata;

	logic                div_start, div_done;
	logic [VT_W-1:0]     div_quo;
	logic [VT_W-1:0]     run_inc;
	logic                accept;

	fvs_ram #(.WIDTH(ENT_W), .DEPTH(MAX_TASKS)) u_task_ram (
		.clk(clk), .we(tr_we), .waddr(tr_waddr), .wdata(tr_wdata),
		.re(tr_re), .raddr(tr_raddr), .rdata(tr_rdata)
	);

	fvs_ram #(.WIDTH(TASK_W), .DEPTH(MAX_TASKS)) u_order_ram (
		.clk(clk), .we(or_we), .waddr(or_waddr), .wdata(or_wdata),
		.re(or_re), .raddr(or_raddr), .rdata(or_rdata)
	);

	// divider takes the freshly read entry while the tick loads it
	fvs_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend({run_inc[VT_W-1-NICE0_SHIFT:0], NICE0_SHIFT'(0)}),
		.divisor(prio_weight(ent.prio)), .done(div_done), .quotient(div_quo)
	);

	assign accept  = start && (state_q == S_IDLE);
	assign busy    = (state_q != S_IDLE);
	assign run_inc = ent.run + 1'b1;

	// unwritten task entries read as reset values
	always_comb begin
		if (vld_rd_q) begin
			ent = tr_rdata;
		end else begin
			ent.run  = '0;
			ent.vt   = '0;
			ent.prio = PRIO_W'(NORMAL_PRIO);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (action)
						ACT_TICK:    state_d = S_T_LOAD;
						ACT_ENQUEUE: state_d = queued_q[task_id] ? S_REPORT : S_E_LOAD;
						ACT_PICK:    state_d = (len_q == '0) ? S_REPORT : S_P_ORDER;
						default:     state_d = S_REPORT;
					endcase
				end
			end
			S_T_LOAD:     state_d = S_T_DIV;
			S_T_DIV:      state_d = div_done ? S_T_CLAMP : S_T_DIV;
			S_T_CLAMP:    state_d = behind(div_quo, floor_q) ? S_T_MUL_LO : S_T_WRITE;
			S_T_MUL_LO:   state_d = S_T_MUL_HI;
			S_T_MUL_HI:   state_d = S_T_SUM;
			S_T_SUM:      state_d = S_T_WRITE;
			S_T_WRITE:    state_d = S_IDLE;
			S_E_LOAD:     state_d = S_E_SCAN;
			S_E_SCAN:     state_d = (i_q == len_q) ? S_E_SHIFT : S_E_SCAN_ID;
			S_E_SCAN_ID:  state_d = S_E_SCAN_CMP;
			S_E_SCAN_CMP: state_d = behind(vt_q, ent.vt) ? S_E_SHIFT : S_E_SCAN;
			S_E_SHIFT:    state_d = (j_q == pos_q) ? S_E_INSERT : S_E_SHIFT_WR;
			S_E_SHIFT_WR: state_d = S_E_SHIFT;
			S_E_INSERT:   state_d = S_IDLE;
			S_P_ORDER:    state_d = S_P_POP;
			S_P_POP:      state_d = S_IDLE;
			S_REPORT:     state_d = S_IDLE;
			default:      state_d = S_IDLE;
		endcase
	end

	// memory and divider controls
	always_comb begin
		tr_re     = 1'b0;
		tr_raddr  = cur_q;
		tr_we     = 1'b0;
		tr_waddr  = who_q;
		tr_wdata  = '{run: run_q, vt: vt_q, prio: prio_q};
		or_re     = 1'b0;
		or_raddr  = head_q;
		or_we     = 1'b0;
		or_waddr  = head_q + j_q[TASK_W-1:0];
		or_wdata  = or_rdata;
		div_start = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (action)
						ACT_ENQUEUE: begin
							tr_re    = 1'b1;
							tr_raddr = task_id;
						end
						ACT_PICK: begin
							tr_re    = (len_q == '0);
							tr_raddr = idle_q;
							or_re    = (len_q != '0);
						end
						default: tr_re = 1'b1;
					endcase
				end
			end
			S_T_LOAD:  div_start = 1'b1;
			S_T_WRITE: tr_we = 1'b1;
			S_E_SCAN: begin
				or_re    = (i_q != len_q);
				or_raddr = head_q + i_q[TASK_W-1:0];
			end
			S_E_SCAN_ID: begin
				tr_re    = 1'b1;
				tr_raddr = or_rdata;
			end
			S_E_SHIFT: begin
				or_re    = (j_q != pos_q);
				or_raddr = head_q + j_q[TASK_W-1:0] - 1'b1;
			end
			S_E_SHIFT_WR: or_we = 1'b1;
			S_E_INSERT: begin
				tr_we    = 1'b1;
				or_we    = 1'b1;
				or_waddr = head_q + pos_q[TASK_W-1:0];
				or_wdata = who_q;
			end
			S_P_ORDER: begin
				tr_re    = 1'b1;
				tr_raddr = or_rdata;
			end
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			idle_q   <= '0;
			cur_q    <= '0;
			head_q   <= '0;
			len_q    <= '0;
			wsum_q   <= '0;
			floor_q  <= '0;
			queued_q <= '0;
			valid_q  <= '0;
			done_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_T_WRITE) || (state_q == S_E_INSERT) ||
				(state_q == S_P_POP) || (state_q == S_REPORT);
			if (cfg_we) begin
				idle_q <= cfg_data;
			end
			if (tr_we) begin
				valid_q[tr_waddr] <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && action == ACT_PICK && len_q == '0) begin
						cur_q <= idle_q;
					end
				end
				S_T_WRITE: begin
					if (behind(floor_q, vt_q)) begin
						floor_q <= vt_q;
					end
				end
				S_E_INSERT: begin
					len_q            <= len_q + 1'b1;
					wsum_q           <= wsum_q + WSUM_W'(prio_weight(prio_q));
					queued_q[who_q]  <= 1'b1;
				end
				S_P_POP: begin
					head_q          <= head_q + 1'b1;
					len_q           <= len_q - 1'b1;
					wsum_q          <= wsum_q - WSUM_W'(prio_weight(ent.prio));
					queued_q[who_q] <= 1'b0;
					cur_q           <= who_q;
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (tr_re) begin
			vld_rd_q <= valid_q[tr_raddr];
		end
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					prio_q <= prio_sat(priority_req);
					case (action)
						ACT_ENQUEUE: begin
							who_q  <= task_id;
							stat_q <= queued_q[task_id] ? ST_DUP : ST_OK;
						end
						ACT_PICK: begin
							who_q  <= idle_q;
							stat_q <= (len_q == '0) ? ST_IDLE : ST_OK;
						end
						default: begin
							who_q  <= cur_q;
							stat_q <= ST_OK;
						end
					endcase
				end
			end
			S_T_LOAD: begin
				run_q  <= run_inc;
				vt_q   <= ent.vt;
				prio_q <= ent.prio;
				w_q    <= prio_weight(ent.prio);
			end
			S_T_CLAMP: vt_q <= behind(div_quo, floor_q) ? floor_q : div_quo;
			S_T_MUL_LO: plo_q <= vt_q[31:0] * w_q;
			S_T_MUL_HI: phi_q <= 32'(vt_q[63:32] * w_q);
			S_T_SUM: begin
				run_q <= VT_W'((VT_W'(plo_q) + {phi_q, 32'b0}) >> NICE0_SHIFT);
			end
			S_E_LOAD: begin
				run_q <= ent.run;
				vt_q  <= ent.vt;
				i_q   <= '0;
			end
			S_E_SCAN: begin
				if (i_q == len_q) begin
					pos_q <= i_q;
					j_q   <= len_q;
				end
			end
			S_E_SCAN_CMP: begin
				if (behind(vt_q, ent.vt)) begin
					pos_q <= i_q;
					j_q   <= len_q;
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
			S_E_SHIFT_WR: j_q <= j_q - 1'b1;
			S_P_ORDER: who_q <= or_rdata;
			default: ;
		endcase
	end

	// result word
	always_ff @(posedge clk) begin
		case (state_q)
			S_T_WRITE: begin
				task_out_q <= who_q;
				vt_out_q   <= vt_q;
				status_q   <= ST_OK;
				count_q    <= len_q;
				weight_q   <= wsum_q;
			end
			S_E_INSERT: begin
				task_out_q <= who_q;
				vt_out_q   <= vt_q;
				status_q   <= ST_OK;
				count_q    <= len_q + 1'b1;
				weight_q   <= wsum_q + WSUM_W'(prio_weight(prio_q));
			end
			S_P_POP: begin
				task_out_q <= who_q;
				vt_out_q   <= ent.vt;
				status_q   <= ST_OK;
				count_q    <= len_q - 1'b1;
				weight_q   <= wsum_q - WSUM_W'(prio_weight(ent.prio));
			end
			S_REPORT: begin
				task_out_q <= who_q;
				vt_out_q   <= ent.vt;
				status_q   <= stat_q;
				count_q    <= len_q;
				weight_q   <= wsum_q;
			end
			default: ;
		endcase
	end

	assign done         = done_q;
	assign task_out     = task_out_q;
	assign vruntime_out = vt_out_q;
	assign status       = status_q;
	assign ready_count  = count_q;
	assign weight_total = weight_q;
endmodule
`default_nettype wire

// File: rtl/fvs_checker.sv
// Port-level checks for the fair scheduler, bound to the top level.
// Depends on fvs_pkg and fair_vruntime_scheduler.
`timescale 1ns / 1ps
`default_nettype none
module fvs_checker
	import fvs_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire logic              done,
	input wire logic [1:0]        status,
	input wire logic [CNT_W-1:0]  ready_count
);
	// a result only ends a command in work
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result word without a command in work");

	// accepted command keeps the block busy
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("command accepted but block not busy");

	// idle task chosen only on an empty queue
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_IDLE) |-> (ready_count == '0))
		else $error("idle task chosen with tasks queued");

	// count stays in range and status is a defined code
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (ready_count <= CNT_W'(MAX_TASKS) &&
			(status == ST_OK || status == ST_DUP || status == ST_IDLE)))
		else $error("result count or status out of range");
endmodule

bind fair_vruntime_scheduler fvs_checker u_fvs_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.status(status), .ready_count(ready_count)
);
`default_nettype wire

// File: dv/fvs_checker.sv
// Scoreboard for the fair virtual-time scheduler: mirrors the task table, the ready
// queue and the floor, predicts each result word and compares it. Depends on fvs_pkg.
`timescale 1ns / 1ps
module fvs_scoreboard
	import fvs_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic                busy,
	input  wire logic [1:0]          action,
	input  wire logic [TASK_W-1:0]   task_id,
	input  wire logic [PRIO_W-1:0]   priority_req,
	input  wire logic                cfg_we,
	input  wire logic [TASK_W-1:0]   cfg_data,
	input  wire logic                done,
	input  wire logic [TASK_W-1:0]   task_out,
	input  wire logic [VT_W-1:0]     vruntime_out,
	input  wire logic [1:0]          status,
	input  wire logic [CNT_W-1:0]    ready_count,
	input  wire logic [WSUM_W-1:0]   weight_total,
	output int                       pending,
	output int                       errors
);
	typedef struct {
		logic [TASK_W-1:0] who;
		logic [VT_W-1:0]   vt;
		logic [1:0]        st;
		logic [CNT_W-1:0]  cnt;
		logic [WSUM_W-1:0] wsum;
	} sched_word_t;

	localparam logic [16:0] WEIGHTS [PRIO_LEVELS] = '{
		17'd88761, 17'd71755, 17'd56483, 17'd46273, 17'd36291, 17'd29154, 17'd23254,
		17'd18705, 17'd14949, 17'd11916, 17'd9548, 17'd7620, 17'd6100, 17'd4904,
		17'd3906, 17'd3121, 17'd2501, 17'd1991, 17'd1586, 17'd1277, 17'd1024, 17'd820,
		17'd655, 17'd526, 17'd423, 17'd335, 17'd272, 17'd215, 17'd172, 17'd137, 17'd110,
		17'd87, 17'd70, 17'd56, 17'd45, 17'd36, 17'd29, 17'd23, 17'd18, 17'd15
	};

	logic [VT_W-1:0]   run_ticks [MAX_TASKS];
	logic [VT_W-1:0]   vtime     [MAX_TASKS];
	logic [PRIO_W-1:0] prio_of   [MAX_TASKS];
	logic              queued    [MAX_TASKS];
	int                ready_q[$];
	logic [VT_W-1:0]   floor_vt;
	logic [WSUM_W-1:0] wsum;
	logic [TASK_W-1:0] running_task;
	logic [TASK_W-1:0] idle_id;
	sched_word_t       expected_words[$];

	function automatic logic lags(input logic [VT_W-1:0] a, input logic [VT_W-1:0] b);
		logic [VT_W-1:0] d;
		d = a - b;
		return d[VT_W-1];
	endfunction

	function automatic logic [VT_W-1:0] weight(input logic [PRIO_W-1:0] p);
		return (p >= PRIO_LEVELS) ? 64'(WEIGHTS[PRIO_LEVELS-1]) : 64'(WEIGHTS[p]);
	endfunction

	// advance the model by one command word and return the word it should produce
	function automatic sched_word_t schedule_step(input logic [1:0] act,
			input logic [TASK_W-1:0] tid, input logic [PRIO_W-1:0] preq);
		sched_word_t res;
		logic [VT_W-1:0] w, r, vr, vt;
		int pos;
		res.st = ST_OK;
		res.who = running_task;
		case (act)
			ACT_TICK: begin
				w = weight(prio_of[running_task]);
				r = run_ticks[running_task] + 64'd1;
				vr = (r * 64'd1024) / w;
				vt = lags(vr, floor_vt) ? floor_vt : vr;
				if (vt != vr)
					r = (vt * w) / 64'd1024;
				run_ticks[running_task] = r;
				vtime[running_task] = vt;
				if (lags(floor_vt, vt))
					floor_vt = vt;
			end
			ACT_ENQUEUE: begin
				res.who = tid;
				if (queued[tid]) begin
					res.st = ST_DUP;
				end else begin
					prio_of[tid] = (preq >= PRIO_LEVELS) ? PRIO_W'(PRIO_LEVELS - 1) : preq;
					pos = 0;
					while (pos < ready_q.size() && !lags(vtime[tid], vtime[ready_q[pos]]))
						pos++;
					ready_q.insert(pos, tid);
					queued[tid] = 1'b1;
					wsum = wsum + WSUM_W'(weight(prio_of[tid]));
				end
			end
			ACT_PICK: begin
				if (ready_q.size() == 0) begin
					running_task = idle_id;
					res.st = ST_IDLE;
				end else begin
					running_task = TASK_W'(ready_q.pop_front());
					queued[running_task] = 1'b0;
					wsum = wsum - WSUM_W'(weight(prio_of[running_task]));
				end
				res.who = running_task;
			end
			default: ;
		endcase
		res.vt = vtime[res.who];
		res.cnt = CNT_W'(ready_q.size());
		res.wsum = wsum;
		return res;
	endfunction

	// track config and commands, compare each result word with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		sched_word_t want;
		if (!arst_n) begin
			for (int i = 0; i < MAX_TASKS; i++) begin
				run_ticks[i] = '0;
				vtime[i] = '0;
				prio_of[i] = PRIO_W'(NORMAL_PRIO);
				queued[i] = 1'b0;
			end
			ready_q.delete();
			expected_words.delete();
			floor_vt = '0;
			wsum = '0;
			idle_id = '0;
			running_task = '0;
			pending = 0;
			errors = 0;
		end else begin
			if (done) begin
				if (expected_words.size() == 0) begin
					$display("%0t: result word with none expected: task %0d vt %0d",
						$time, task_out, vruntime_out);
					errors++;
				end else begin
					want = expected_words.pop_front();
					if (task_out !== want.who) begin
						$display("%0t: task_out expected %0d actual %0d",
							$time, want.who, task_out);
						errors++;
					end
					if (vruntime_out !== want.vt) begin
						$display("%0t: vruntime_out expected %0d actual %0d",
							$time, want.vt, vruntime_out);
						errors++;
					end
					if (status !== want.st) begin
						$display("%0t: status expected %0d actual %0d", $time, want.st, status);
						errors++;
					end
					if (ready_count !== want.cnt) begin
						$display("%0t: ready_count expected %0d actual %0d",
							$time, want.cnt, ready_count);
						errors++;
					end
					if (weight_total !== want.wsum) begin
						$display("%0t: weight_total expected %0d actual %0d",
							$time, want.wsum, weight_total);
						errors++;
					end
				end
			end
			if (cfg_we)
				idle_id = cfg_data;
			if (start && !busy)
				expected_words.push_back(schedule_step(action, task_id, priority_req));
			pending = expected_words.size();
		end
	end
endmodule

// File: dv/testbench.sv
// Top of the scheduler regression: clock, reset, command stimulus and idle-task
// writes. Depends on fvs_pkg, fair_vruntime_scheduler and fvs_scoreboard.
`timescale 1ns / 1ps
module testbench
	import fvs_pkg::*;
();
	localparam logic [1:0] ACT_NOP = 2'd3;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic [1:0]        action = ACT_TICK;
	logic [TASK_W-1:0] task_id = '0;
	logic [PRIO_W-1:0] priority_req = '0;
	logic              cfg_we = 1'b0;
	logic [TASK_W-1:0] cfg_data = '0;
	wire               busy, done;
	wire  [TASK_W-1:0] task_out;
	wire  [VT_W-1:0]   vruntime_out;
	wire  [1:0]        status;
	wire  [CNT_W-1:0]  ready_count;
	wire  [WSUM_W-1:0] weight_total;
	int                pending, errors;
	logic              gaps_on = 1'b1;

	fair_vruntime_scheduler u_dut (
		.clk, .arst_n, .start, .busy, .action, .task_id, .priority_req,
		.cfg_we, .cfg_data, .done, .task_out, .vruntime_out, .status,
		.ready_count, .weight_total
	);

	fvs_scoreboard u_checker (
		.clk, .arst_n, .start, .busy, .action, .task_id, .priority_req,
		.cfg_we, .cfg_data, .done, .task_out, .vruntime_out, .status,
		.ready_count, .weight_total, .pending, .errors
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// hold start until the word is taken, then maybe insert an idle burst
	task automatic issue(input logic [1:0] act, input logic [TASK_W-1:0] tid,
			input logic [PRIO_W-1:0] prio);
		action <= act;
		task_id <= tid;
		priority_req <= prio;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// drain all results, let the block settle, then write the idle task register
	task automatic set_idle_task(input logic [TASK_W-1:0] id);
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= id;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_word(input int enq_pct, input int pick_pct);
		int roll;
		logic [PRIO_W-1:0] prio;
		roll = $urandom_range(0, 99);
		prio = ($urandom_range(0, 7) == 0) ? PRIO_W'($urandom_range(0, 63))
			: PRIO_W'($urandom_range(0, 39));
		if (roll < enq_pct)
			issue(ACT_ENQUEUE, TASK_W'($urandom_range(0, 63)), prio);
		else if (roll < enq_pct + pick_pct)
			issue(ACT_PICK, TASK_W'($urandom), PRIO_W'($urandom));
		else if (roll < 96)
			issue(ACT_TICK, TASK_W'($urandom), PRIO_W'($urandom));
		else
			issue(ACT_NOP, TASK_W'($urandom), PRIO_W'($urandom));
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_idle_task(6'd63);

		// directed: empty pick, idle ticks, queued current task, extremes, dup, nop
		issue(ACT_PICK, 6'd0, 6'd0);
		issue(ACT_TICK, 6'd0, 6'd0);
		issue(ACT_TICK, 6'd0, 6'd0);
		issue(ACT_ENQUEUE, 6'd63, 6'd20);
		issue(ACT_TICK, 6'd0, 6'd0);
		issue(ACT_ENQUEUE, 6'd0, 6'd0);
		issue(ACT_ENQUEUE, 6'd5, 6'd39);
		issue(ACT_ENQUEUE, 6'd6, 6'd63);
		issue(ACT_ENQUEUE, 6'd42, 6'd40);
		issue(ACT_ENQUEUE, 6'd0, 6'd39);
		issue(ACT_NOP, 6'd42, 6'd21);
		issue(ACT_PICK, 6'd0, 6'd0);
		repeat (3) issue(ACT_TICK, 6'd0, 6'd0);
		issue(ACT_ENQUEUE, 6'd21, 6'd1);
		repeat (6) issue(ACT_PICK, 6'd63, 6'd63);
		issue(ACT_TICK, 6'd0, 6'd0);

		// random phases with differing mixes and idle task settings
		set_idle_task(6'd0);
		repeat (250) random_word(55, 25);
		set_idle_task(TASK_W'($urandom_range(1, 62)));
		repeat (250) random_word(35, 35);
		set_idle_task(6'd63);
		repeat (250) random_word(45, 30);
		set_idle_task(6'd21);
		gaps_on = 1'b0;
		repeat (250) random_word(40, 30);
		start <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("fair_vruntime_scheduler regression: pass");
		else
			$display("fair_vruntime_scheduler regression: fail");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("fair_vruntime_scheduler regression: fail");
		$finish;
	end
endmodule
